// ----- rtl/core/qxmm_pkg.sv -----
// qxmm_pkg: shared types and constants of the x-quadrotor motor mixer
// used by qxmm_sqrt_pipe and quad_x_motor_mixer; no dependencies
`timescale 1ns / 1ps

package qxmm_pkg;

	localparam int CMD_W   = 32;
	localparam int RPM_W   = 16;
	localparam int LANES   = 4;
	localparam int RAD_W   = 64;
	localparam int ROOT_W  = 32;
	localparam int REM_W   = 35;
	localparam int STEPS_PER_STAGE = 2;
	localparam int SQ_STAGES = ROOT_W / STEPS_PER_STAGE;

	// configuration register indexes
	localparam logic [2:0] REG_ROLL_PITCH_GAIN = 3'd0;
	localparam logic [2:0] REG_YAW_GAIN        = 3'd1;
	localparam logic [2:0] REG_RPM_SQ_SCALE    = 3'd2;
	localparam logic [2:0] REG_LOWEST_RPM      = 3'd3;
	localparam logic [2:0] REG_HIGHEST_RPM     = 3'd4;

	// flags that ride along the root pipeline
	typedef struct packed {
		logic sat;
		logic ok;
	} side_t;

	// partial state of one digit-by-digit root lane
	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

endpackage

// ----- rtl/core/quad_x_motor_mixer.sv -----
// quad_x_motor_mixer: top level of the x-quadrotor motor mixer
// depends on qxmm_pkg and qxmm_sqrt_pipe
`timescale 1ns / 1ps

// one wrench beat in (thrust, roll, pitch, yaw, signed fixed point with
// FRAC_BITS fraction bits) gives one beat out with four motor rpm values,
// saturated and valid_res. the block takes a beat every cycle unless the
// output beat is held. it has 5 arithmetic stages, 16 square-root stages
// (two root bits each) and the output register. a held output beat
// freezes the whole pipeline, so nothing is lost. an overflowing torque
// term gives valid_res=0, zero rpm and saturated=1. configuration must be
// written only while the pipeline is empty; the block does not enforce it.
module quad_x_motor_mixer #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// config write port
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	// input stream, tdata: thrust_cmd, roll_cmd, pitch_cmd, yaw_cmd
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,
	// output stream, tdata: rpm_one, rpm_two, rpm_three, rpm_four,
	// saturated, valid_res, zero pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata
);

	localparam int W = qxmm_pkg::CMD_W;
	localparam int L = qxmm_pkg::LANES;

	// config registers
	logic [31:0] rp_gain_q, yaw_gain_q, sq_scale_q;
	logic [15:0] lo_rpm_q, hi_rpm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_gain_q  <= 32'd370727;
			yaw_gain_q <= 32'd4096000;
			sq_scale_q <= 32'd9118906;
			lo_rpm_q   <= 16'd0;
			hi_rpm_q   <= 16'd20000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				qxmm_pkg::REG_ROLL_PITCH_GAIN: rp_gain_q  <= cfg_data;
				qxmm_pkg::REG_YAW_GAIN:        yaw_gain_q <= cfg_data;
				qxmm_pkg::REG_RPM_SQ_SCALE:    sq_scale_q <= cfg_data;
				qxmm_pkg::REG_LOWEST_RPM:      lo_rpm_q   <= cfg_data[15:0];
				qxmm_pkg::REG_HIGHEST_RPM:     hi_rpm_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// whole pipeline moves together unless the output beat is held
	logic adv;
	logic out_v_q;
	assign adv      = !out_v_q || m_tready;
	assign s_tready = adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: thrust clamp, torque magnitudes (roll, pitch, yaw)
	logic [W-1:0] thr_s1, thr_s2, thr_s3;
	logic         sat_s1, sat_s2, sat_s3, sat_s4, sat_s5;
	logic [W-1:0] mag_s1 [3];
	logic         neg_s1 [3];
	logic         neg_s2 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			sat_s1 <= s_tdata[W-1];
			thr_s1 <= s_tdata[W-1] ? '0 : s_tdata[W-1:0];
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= s_tdata[W*(i+1)+W-1];
				mag_s1[i] <= s_tdata[W*(i+1)+W-1] ? W'(-s_tdata[W*(i+1) +: W])
				                                  : s_tdata[W*(i+1) +: W];
			end
		end
	end

	// stage 2: magnitude times gain
	logic [2*W-1:0] prod_s2 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			thr_s2 <= thr_s1;
			sat_s2 <= sat_s1;
			neg_s2 <= neg_s1;
			prod_s2[0] <= 64'(mag_s1[0]) * 64'(rp_gain_q);
			prod_s2[1] <= 64'(mag_s1[1]) * 64'(rp_gain_q);
			prod_s2[2] <= 64'(mag_s1[2]) * 64'(yaw_gain_q);
		end
	end

	// stage 3: scale down, range check, restore sign
	logic signed [W:0] term_s3 [3];
	logic              ok_s3, ok_s4, ok_s5;
	logic [2*W-1:0]    q_c [3];
	logic              ovf_c;

	always_comb begin
		ovf_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			q_c[i] = prod_s2[i] >> FRAC_BITS;
			if (neg_s2[i]) begin
				if (q_c[i] > 64'h8000_0000) ovf_c = 1'b1;
			end else begin
				if (q_c[i] > 64'h7FFF_FFFF) ovf_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			thr_s3 <= thr_s2;
			sat_s3 <= sat_s2;
			ok_s3  <= !ovf_c;
			for (int i = 0; i < 3; i++) begin
				term_s3[i] <= neg_s2[i] ? -$signed({1'b0, q_c[i][W-1:0]})
				                        : $signed({1'b0, q_c[i][W-1:0]});
			end
		end
	end

	// stage 4: inverse mixing per motor, negative thrust clamp, quarter
	logic signed [W+2:0] sum_c [L];
	logic [W-1:0]        mt_s4 [L];
	logic                neg_sum_c;

	always_comb begin
		logic signed [W+2:0] t, r, p, y;
		t = $signed({3'b000, thr_s3});
		r = (W+3)'(term_s3[0]);
		p = (W+3)'(term_s3[1]);
		y = (W+3)'(term_s3[2]);
		// motor 1: +r -p -y, 2: +r +p +y, 3: -r +p -y, 4: -r -p +y
		sum_c[0] = t + r - p - y;
		sum_c[1] = t + r + p + y;
		sum_c[2] = t - r + p - y;
		sum_c[3] = t - r - p + y;
		neg_sum_c = 1'b0;
		for (int k = 0; k < L; k++) begin
			if (sum_c[k][W+2]) neg_sum_c = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s4  <= ok_s3;
			sat_s4 <= sat_s3 || neg_sum_c;
			for (int k = 0; k < L; k++) begin
				mt_s4[k] <= sum_c[k][W+2] ? '0 : sum_c[k][W+1:2];
			end
		end
	end

	// stage 5: motor thrust times rpm-squared scale
	logic [2*W-1:0] psq_s5 [L];

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s5  <= ok_s4;
			sat_s5 <= sat_s4;
			for (int k = 0; k < L; k++) begin
				psq_s5[k] <= 64'(mt_s4[k]) * 64'(sq_scale_q);
			end
		end
	end

	// square root pipeline
	logic [qxmm_pkg::RAD_W-1:0]  rad_c [L];
	logic [qxmm_pkg::ROOT_W-1:0] root  [L];
	qxmm_pkg::side_t             side_in, side_out;
	logic                        sq_v;

	for (genvar k = 0; k < L; k++) begin : g_rad
		assign rad_c[k] = qxmm_pkg::RAD_W'(psq_s5[k] >> FRAC_BITS);
	end
	assign side_in = '{sat: sat_s5, ok: ok_s5};

	qxmm_sqrt_pipe u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_v    (v_s5),
		.in_rad  (rad_c),
		.in_side (side_in),
		.out_v   (sq_v),
		.out_root(root),
		.out_side(side_out)
	);

	// rpm clamp and output register
	logic [qxmm_pkg::RPM_W-1:0] rpm_c [L];
	logic                       clamp_c;
	logic [qxmm_pkg::RPM_W-1:0] rpm_q [L];
	logic                       sat_q, ok_q;

	always_comb begin
		logic [qxmm_pkg::ROOT_W-1:0] c;
		clamp_c = 1'b0;
		for (int k = 0; k < L; k++) begin
			c = root[k];
			if (c < 32'(lo_rpm_q)) c = 32'(lo_rpm_q);
			if (c > 32'(hi_rpm_q)) c = 32'(hi_rpm_q);
			if (c != root[k]) clamp_c = 1'b1;
			rpm_c[k] = side_out.ok ? c[qxmm_pkg::RPM_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rpm_q <= rpm_c;
			ok_q  <= side_out.ok;
			sat_q <= !side_out.ok || side_out.sat || clamp_c;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {6'b0, ok_q, sat_q, rpm_q[3], rpm_q[2], rpm_q[1], rpm_q[0]};

endmodule

// ----- rtl/core/qxmm_sqrt_pipe.sv -----
// qxmm_sqrt_pipe: four-lane pipelined integer square root, two bits a stage
// depends on qxmm_pkg
`timescale 1ns / 1ps

module qxmm_sqrt_pipe (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_v,
	input  logic [qxmm_pkg::RAD_W-1:0] in_rad [qxmm_pkg::LANES],
	input  qxmm_pkg::side_t in_side,
	output logic out_v,
	output logic [qxmm_pkg::ROOT_W-1:0] out_root [qxmm_pkg::LANES],
	output qxmm_pkg::side_t out_side
);

	function automatic qxmm_pkg::sq_t sq_step(input qxmm_pkg::sq_t a);
		qxmm_pkg::sq_t r;
		logic [qxmm_pkg::REM_W-1:0] rem2;
		logic [qxmm_pkg::REM_W-1:0] trial;
		rem2  = {a.rem[qxmm_pkg::REM_W-3:0], a.rad[qxmm_pkg::RAD_W-1 -: 2]};
		trial = {1'b0, a.root, 2'b01};
		r.rad = {a.rad[qxmm_pkg::RAD_W-3:0], 2'b00};
		if (rem2 >= trial) begin
			r.rem  = rem2 - trial;
			r.root = {a.root[qxmm_pkg::ROOT_W-2:0], 1'b1};
		end else begin
			r.rem  = rem2;
			r.root = {a.root[qxmm_pkg::ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	logic            v_s    [qxmm_pkg::SQ_STAGES+1];
	qxmm_pkg::side_t side_s [qxmm_pkg::SQ_STAGES+1];
	qxmm_pkg::sq_t   st_s   [qxmm_pkg::SQ_STAGES+1][qxmm_pkg::LANES];

	assign v_s[0]    = in_v;
	assign side_s[0] = in_side;

	for (genvar l = 0; l < qxmm_pkg::LANES; l++) begin : g_in
		assign st_s[0][l] = '{rad: in_rad[l], rem: '0, root: '0};
		assign out_root[l] = st_s[qxmm_pkg::SQ_STAGES][l].root;
	end

	for (genvar g = 0; g < qxmm_pkg::SQ_STAGES; g++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[g+1] <= side_s[g];
				for (int l = 0; l < qxmm_pkg::LANES; l++) begin
					st_s[g+1][l] <= sq_step(sq_step(st_s[g][l]));
				end
			end
		end
	end

	assign out_v    = v_s[qxmm_pkg::SQ_STAGES];
	assign out_side = side_s[qxmm_pkg::SQ_STAGES];

endmodule

// ----- test/qxmm_checker.sv -----
// qxmm_checker: watches both streams of the motor mixer, predicts each output beat
// and compares it field by field; depends on qxmm_pkg for register indexes
`timescale 1ns / 1ps

module qxmm_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [127:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [71:0]  m_tdata,
	output int           fail_count,
	output int           pending
);

	typedef struct packed {
		logic        valid_res;
		logic        saturated;
		logic [15:0] rpm4;
		logic [15:0] rpm3;
		logic [15:0] rpm2;
		logic [15:0] rpm1;
	} mix_out_t;

	logic [31:0] rp_gain, y_gain, sq_scale;
	logic [15:0] rpm_lo, rpm_hi;
	mix_out_t    rpm_queue[$];

	assign pending = rpm_queue.size();

	function automatic logic [63:0] root_floor(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// magnitude times gain, truncated toward zero; ok cleared when out of int32
	function automatic longint torque_term(logic signed [31:0] cmd, logic [31:0] gain,
			inout logic ok);
		logic [63:0] mag, q;
		mag = cmd < 0 ? 64'(-longint'(cmd)) : 64'(cmd);
		q = (mag * 64'(gain)) >> FRAC_BITS;
		if (cmd < 0) begin
			if (q > 64'h8000_0000) ok = 1'b0;
			return -longint'(q);
		end
		if (q > 64'h7FFF_FFFF) ok = 1'b0;
		return longint'(q);
	endfunction

	function automatic mix_out_t mix_wrench(logic [127:0] d);
		mix_out_t o;
		longint th, rt, pt, yt, sum;
		logic ok, sat;
		logic [63:0] mt, rpm, cl;
		logic [15:0] lane [4];
		int sr [4] = '{1, 1, -1, -1};
		int sp [4] = '{-1, 1, 1, -1};
		int sy [4] = '{-1, 1, -1, 1};
		ok = 1'b1;
		sat = 1'b0;
		th = longint'(signed'(d[31:0]));
		if (th < 0) begin
			th = 0;
			sat = 1'b1;
		end
		rt = torque_term(d[63:32], rp_gain, ok);
		pt = torque_term(d[95:64], rp_gain, ok);
		yt = torque_term(d[127:96], y_gain, ok);
		o = '0;
		if (!ok) begin
			o.saturated = 1'b1;
			return o;
		end
		for (int k = 0; k < 4; k++) begin
			sum = th + sr[k] * rt + sp[k] * pt + sy[k] * yt;
			if (sum < 0) begin
				mt = 0;
				sat = 1'b1;
			end else begin
				mt = 64'(sum) >> 2;
			end
			rpm = root_floor((mt * 64'(sq_scale)) >> FRAC_BITS);
			cl = rpm;
			if (cl < 64'(rpm_lo)) cl = 64'(rpm_lo);
			if (cl > 64'(rpm_hi)) cl = 64'(rpm_hi);
			if (cl != rpm) sat = 1'b1;
			lane[k] = cl[15:0];
		end
		o.rpm1 = lane[0];
		o.rpm2 = lane[1];
		o.rpm3 = lane[2];
		o.rpm4 = lane[3];
		o.saturated = sat;
		o.valid_res = 1'b1;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mix_out_t got, exp_o;
		if (!arst_n) begin
			rp_gain <= 32'd370727;
			y_gain <= 32'd4096000;
			sq_scale <= 32'd9118906;
			rpm_lo <= 16'd0;
			rpm_hi <= 16'd20000;
			fail_count <= 0;
			rpm_queue.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					qxmm_pkg::REG_ROLL_PITCH_GAIN: rp_gain <= cfg_data;
					qxmm_pkg::REG_YAW_GAIN:        y_gain <= cfg_data;
					qxmm_pkg::REG_RPM_SQ_SCALE:    sq_scale <= cfg_data;
					qxmm_pkg::REG_LOWEST_RPM:      rpm_lo <= cfg_data[15:0];
					qxmm_pkg::REG_HIGHEST_RPM:     rpm_hi <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) rpm_queue.push_back(mix_wrench(s_tdata));
			if (m_tvalid && m_tready) begin
				got = m_tdata[65:0];
				if (rpm_queue.size() == 0) begin
					$error("output beat with nothing expected: %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					exp_o = rpm_queue.pop_front();
					if (got != exp_o) begin
						fail_count <= fail_count + 1;
						if (got.rpm1 != exp_o.rpm1)
							$error("rpm_one exp %0d got %0d", exp_o.rpm1, got.rpm1);
						if (got.rpm2 != exp_o.rpm2)
							$error("rpm_two exp %0d got %0d", exp_o.rpm2, got.rpm2);
						if (got.rpm3 != exp_o.rpm3)
							$error("rpm_three exp %0d got %0d", exp_o.rpm3, got.rpm3);
						if (got.rpm4 != exp_o.rpm4)
							$error("rpm_four exp %0d got %0d", exp_o.rpm4, got.rpm4);
						if (got.saturated != exp_o.saturated)
							$error("saturated exp %0d got %0d", exp_o.saturated,
								got.saturated);
						if (got.valid_res != exp_o.valid_res)
							$error("valid_res exp %0d got %0d", exp_o.valid_res,
								got.valid_res);
					end
				end
			end
		end
	end
endmodule

// ----- test/tb_quad_x_motor_mixer.sv -----
// tb_quad_x_motor_mixer: stimulus and verdict for the motor mixer
// depends on qxmm_pkg, quad_x_motor_mixer and qxmm_checker
`timescale 1ns / 1ps

module tb_quad_x_motor_mixer;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// fields from bit 0: thrust_cmd, roll_cmd, pitch_cmd, yaw_cmd
	logic [127:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// fields from bit 0: rpm_one..rpm_four, saturated, valid_res, zero pad
	logic [71:0]  m_tdata;
	int           fail_count, pending;

	// idle percentages per phase, and the long receiver hold-off
	int send_idle = 35, recv_idle = 50;
	bit hold_off = 1'b0;

	always #5 clk = ~clk;

	quad_x_motor_mixer dut (.*);
	qxmm_checker chk (.*);

	// receiver: random stalls, or a long stretch of none while hold_off is set
	always @(posedge clk) begin
		if (hold_off) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(99) >= recv_idle);
	end

	// a random command word; mostly modest values so the mixer sees real flight
	function automatic logic [31:0] rand_cmd(bit torque);
		case ($urandom_range(7))
			0: return $urandom;
			1: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			2: return 32'h8000_0000 | $urandom_range(3);
			3: return 32'h7FFF_FFFF - $urandom_range(3);
			default: return torque ? 32'(signed'($urandom_range(131072)) - 65536)
				: 32'($urandom_range(2_000_000));
		endcase
	endfunction

	// send one beat, held until accepted; valid stays up for a following beat
	task automatic send_cmd(logic [31:0] t, logic [31:0] r, logic [31:0] p,
			logic [31:0] y);
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {y, p, r, t};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// drop valid and wait for the pipeline to empty; only then touch the registers
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic write_all(logic [31:0] rp, logic [31:0] yg, logic [31:0] sc,
			logic [15:0] lo, logic [15:0] hi);
		write_reg(qxmm_pkg::REG_ROLL_PITCH_GAIN, rp);
		write_reg(qxmm_pkg::REG_YAW_GAIN, yg);
		write_reg(qxmm_pkg::REG_RPM_SQ_SCALE, sc);
		write_reg(qxmm_pkg::REG_LOWEST_RPM, lo);
		write_reg(qxmm_pkg::REG_HIGHEST_RPM, hi);
		write_reg(3'd7, $urandom); // unused index, must be ignored
		cfg_we <= 1'b0;
	endtask

	task automatic random_burst(int n);
		repeat (n) send_cmd(rand_cmd(0), rand_cmd(1), rand_cmd(1), rand_cmd(1));
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: hover, extremes, negative thrust, overflowing torques
		send_cmd(32'd0, 32'd0, 32'd0, 32'd0);
		send_cmd(32'h0005_0000, 32'd0, 32'd0, 32'd0);
		send_cmd(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0);
		send_cmd(32'h8000_0000, 32'd0, 32'd0, 32'd0);
		send_cmd(32'hFFFF_FFFF, 32'h0001_0000, 32'd0, 32'd0);
		send_cmd(32'h0010_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
		send_cmd(32'h0001_0000, 32'h7FFF_FFFF, 32'd0, 32'd0);
		send_cmd(32'h0001_0000, 32'd0, 32'h8000_0000, 32'd0);
		send_cmd(32'h0001_0000, 32'd0, 32'd0, 32'h7FFF_FFFF);
		send_cmd(32'h0001_0000, 32'd0, 32'd0, 32'h8000_0000);
		send_cmd(32'h0100_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_cmd(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		drain();

		// unit gains: a most-negative torque scales to exactly -2^31, no overflow
		write_all(32'h0001_0000, 32'h0001_0000, 32'd1000, 16'd100, 16'd65535);
		send_cmd(32'h0001_0000, 32'h8000_0000, 32'd0, 32'd0);
		send_cmd(32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd0);
		send_cmd(32'd0, 32'd0, 32'd0, 32'd0);
		random_burst(100);
		drain();

		// swap idling, then crossed limits and top-end scale
		send_idle = 50;
		recv_idle = 35;
		write_all(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 16'd5000, 16'd3000);
		random_burst(130);
		drain();

		// receiver holds off while the sender keeps pushing: pipeline fills
		send_idle = 0;
		recv_idle = 0;
		write_all(32'd0, 32'hFFFF_FFFF, 32'd0, 16'd65535, 16'd65535);
		hold_off = 1'b1;
		fork
			random_burst(80);
			begin
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end
		join
		drain();

		write_all(32'd370727, 32'd4096000, 32'd9118906, 16'd0, 16'd20000);
		random_burst(320);
		drain();

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ----- quad_x_motor_mixer.f -----
rtl/core/qxmm_pkg.sv
rtl/core/qxmm_sqrt_pipe.sv
rtl/core/quad_x_motor_mixer.sv
test/qxmm_checker.sv
test/tb_quad_x_motor_mixer.sv
